// ===== design/mdct_pkg.sv =====
// package for the motion direction cycle tracker
// holds field widths, direction and cycle codes, register indexes and scale constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mdct_pkg;

	localparam int SampleW  = 12;
	localparam int TimeW    = 32;
	localparam int ThreshW  = 16;
	localparam int HoldW    = 16;
	localparam int DiffW    = SampleW + 1;
	localparam int ScaledW  = 24;
	localparam int DivSteps = ScaledW - 1;
	localparam int DivCntW  = $clog2(DivSteps);
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam int InDataW  = 48;
	localparam int OutDataW = 32;

	localparam logic signed [11:0]      ScaleSpan = 12'sd2000;
	localparam logic signed [ScaledW-1:0] ScaleLow = -24'sd1000;

	typedef enum logic [1:0] {
		DIR_NONE     = 2'd0,
		DIR_FORWARD  = 2'd1,
		DIR_BACKWARD = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		CYC_CLOSED  = 2'd0,
		CYC_OPENING = 2'd1,
		CYC_OPEN    = 2'd2,
		CYC_CLOSING = 2'd3
	} cyc_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RAW_LOW   = 3'd0,
		CFG_RAW_HIGH  = 3'd1,
		CFG_FWD_THR   = 3'd2,
		CFG_BWD_THR   = 3'd3,
		CFG_HOLDOFF   = 3'd4
	} cfg_idx_t;

endpackage

`default_nettype wire

// ===== design/mdct_div.sv =====
// serial restoring divider, one quotient bit per cycle, truncates toward zero
// signed dividend and divisor in, signed quotient out
// depends on mdct_pkg
`timescale 1ns / 1ps
`default_nettype none

module mdct_div (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic signed [mdct_pkg::ScaledW-1:0]    dividend,
	input  wire logic signed [mdct_pkg::DiffW-1:0]      divisor,
	output logic                                        done,
	output logic signed [mdct_pkg::ScaledW-1:0]         quotient
);

	localparam int MagW = mdct_pkg::ScaledW - 1;
	localparam int DvsW = mdct_pkg::DiffW - 1;
	localparam int DivSteps = mdct_pkg::DivSteps;

	logic                        busy_q;
	logic                        done_q;
	logic [mdct_pkg::DivCntW-1:0] cnt_q;
	logic [MagW-1:0]             quo_q;
	logic [DvsW-1:0]             rem_q;
	logic [DvsW-1:0]             dvs_q;
	logic                        neg_q;

	logic [mdct_pkg::ScaledW-1:0] dvd_abs;
	logic [mdct_pkg::DiffW-1:0]   dvs_abs;
	logic [DvsW:0]                trial;
	logic                         fits;
	logic [mdct_pkg::ScaledW-1:0] quo_ext;

	assign dvd_abs = dividend[mdct_pkg::ScaledW-1] ? -dividend : dividend;
	assign dvs_abs = divisor[mdct_pkg::DiffW-1] ? -divisor : divisor;

	assign trial = {rem_q, quo_q[MagW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mdct_pkg::DivCntW'(DivSteps - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - mdct_pkg::DivCntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd_abs[MagW-1:0];
			rem_q <= '0;
			dvs_q <= dvs_abs[DvsW-1:0];
			neg_q <= dividend[mdct_pkg::ScaledW-1] ^ divisor[mdct_pkg::DiffW-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[MagW-2:0], fits};
			rem_q <= fits ? DvsW'(trial - {1'b0, dvs_q}) : trial[DvsW-1:0];
		end
	end

	assign quo_ext  = {1'b0, quo_q};
	assign quotient = neg_q ? -$signed(quo_ext) : $signed(quo_ext);
	assign done     = done_q;

endmodule

`default_nettype wire

// ===== design/motion_direction_cycle_tracker.sv =====
// top level of the motion direction cycle tracker: sequencer, scaling, classification
// and the four-state cycle; uses mdct_div for the scaling divide
// depends on mdct_pkg and mdct_div
//
// channel   direction  fields
// s_*       in         tdata: sample[11:0], now_ms[43:12], zero pad to 48
// m_*       out        tdata: evaluated, scaled_value, direction_seen, cycle_state,
//                      state_changed, zero pad to 32
// cfg_*     in         write enable, register index, data
//
// an evaluated item with a nonzero span passes from the multiply step through the divider
// start and the divider wait, where the 23 bit serial divide runs, to the finish step;
// an item inside the holdoff or with a zero span goes from the multiply step straight
// to the finish step. s_tready is high only while the sequencer is idle.
// a finished result waits in the output register; the next item is taken meanwhile,
// and the sequencer holds its last step while the output register is still full.
// reset returns the configuration and tracker registers to their defaults, cycle closed, no pending direction.
`timescale 1ns / 1ps
`default_nettype none

module motion_direction_cycle_tracker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// sample[11:0], now_ms[43:12], zeros[47:44]
	input  wire logic [mdct_pkg::InDataW-1:0]     s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// evaluated[0], scaled_value[24:1], direction_seen[26:25], cycle_state[28:27],
	// state_changed[29], zeros[31:30]
	output logic [mdct_pkg::OutDataW-1:0]         m_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [mdct_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [mdct_pkg::CfgDataW-1:0]    cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_DIVGO = 5'b00100,
		ST_DIVW  = 5'b01000,
		ST_FIN   = 5'b10000
	} seq_t;

	seq_t state_q;

	logic [mdct_pkg::SampleW-1:0]        raw_low_q;
	logic [mdct_pkg::SampleW-1:0]        raw_high_q;
	logic signed [mdct_pkg::ThreshW-1:0] fwd_thr_q;
	logic signed [mdct_pkg::ThreshW-1:0] bwd_thr_q;
	logic [mdct_pkg::HoldW-1:0]          holdoff_q;

	mdct_pkg::cyc_t               cyc_q;
	mdct_pkg::dir_t               pending_q;
	logic [mdct_pkg::TimeW-1:0]   last_q;

	logic [mdct_pkg::SampleW-1:0]        sample_q;
	logic [mdct_pkg::TimeW-1:0]          now_q;
	logic                                eval_q;
	logic signed [mdct_pkg::ScaledW-1:0] num_q;
	logic signed [mdct_pkg::DiffW-1:0]   span_q;
	logic signed [mdct_pkg::ScaledW-1:0] scaled_q;

	logic [mdct_pkg::OutDataW-1:0] out_q;
	logic                          out_valid_q;

	logic                                s_acc;
	logic                                out_free;
	logic [mdct_pkg::TimeW-1:0]          elapsed;
	logic                                holdoff_done;
	logic signed [mdct_pkg::DiffW-1:0]   diff;
	logic signed [mdct_pkg::DiffW-1:0]   span;
	logic signed [mdct_pkg::ScaledW:0]   prod;
	logic                                div_start;
	logic                                div_done;
	logic signed [mdct_pkg::ScaledW-1:0] div_quo;
	logic signed [mdct_pkg::ScaledW-1:0] fwd_ext;
	logic signed [mdct_pkg::ScaledW-1:0] bwd_ext;
	mdct_pkg::dir_t                      seen;
	mdct_pkg::dir_t                      pend;
	mdct_pkg::cyc_t                      cyc_next;
	logic                                changed;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign div_start = (state_q == ST_DIVGO);

	assign elapsed      = now_q - last_q;
	assign holdoff_done = elapsed >= {{(mdct_pkg::TimeW - mdct_pkg::HoldW){1'b0}}, holdoff_q};
	assign diff         = $signed({1'b0, sample_q}) - $signed({1'b0, raw_low_q});
	assign span         = $signed({1'b0, raw_high_q}) - $signed({1'b0, raw_low_q});
	assign prod         = (mdct_pkg::ScaledW + 1)'(diff)
		* (mdct_pkg::ScaledW + 1)'(mdct_pkg::ScaleSpan);

	mdct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (span_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign fwd_ext = {{(mdct_pkg::ScaledW - mdct_pkg::ThreshW){fwd_thr_q[mdct_pkg::ThreshW-1]}},
		fwd_thr_q};
	assign bwd_ext = {{(mdct_pkg::ScaledW - mdct_pkg::ThreshW){bwd_thr_q[mdct_pkg::ThreshW-1]}},
		bwd_thr_q};

	always_comb begin
		seen = mdct_pkg::DIR_NONE;
		if (eval_q) begin
			priority if (scaled_q > fwd_ext) begin
				seen = mdct_pkg::DIR_FORWARD;
			end else if (scaled_q < bwd_ext) begin
				seen = mdct_pkg::DIR_BACKWARD;
			end else begin
				seen = mdct_pkg::DIR_NONE;
			end
		end
		pend = (seen != mdct_pkg::DIR_NONE) ? seen : pending_q;
		cyc_next = cyc_q;
		priority if (cyc_q == mdct_pkg::CYC_OPEN && pend == mdct_pkg::DIR_FORWARD) begin
			cyc_next = mdct_pkg::CYC_CLOSING;
		end else if (cyc_q == mdct_pkg::CYC_CLOSING && pend == mdct_pkg::DIR_BACKWARD) begin
			cyc_next = mdct_pkg::CYC_CLOSED;
		end else if (cyc_q == mdct_pkg::CYC_CLOSED && pend == mdct_pkg::DIR_BACKWARD) begin
			cyc_next = mdct_pkg::CYC_OPENING;
		end else if (cyc_q == mdct_pkg::CYC_OPENING && pend == mdct_pkg::DIR_FORWARD) begin
			cyc_next = mdct_pkg::CYC_OPEN;
		end else begin
			cyc_next = cyc_q;
		end
		changed = eval_q && (cyc_next != cyc_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_low_q  <= 12'd400;
			raw_high_q <= 12'd600;
			fwd_thr_q  <= 16'sd200;
			bwd_thr_q  <= -16'sd200;
			holdoff_q  <= 16'd800;
		end else if (cfg_we) begin
			unique case (mdct_pkg::cfg_idx_t'(cfg_index))
				mdct_pkg::CFG_RAW_LOW:  raw_low_q  <= cfg_data[mdct_pkg::SampleW-1:0];
				mdct_pkg::CFG_RAW_HIGH: raw_high_q <= cfg_data[mdct_pkg::SampleW-1:0];
				mdct_pkg::CFG_FWD_THR:  fwd_thr_q  <= $signed(cfg_data);
				mdct_pkg::CFG_BWD_THR:  bwd_thr_q  <= $signed(cfg_data);
				mdct_pkg::CFG_HOLDOFF:  holdoff_q  <= cfg_data[mdct_pkg::HoldW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cyc_q       <= mdct_pkg::CYC_CLOSED;
			pending_q   <= mdct_pkg::DIR_NONE;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (holdoff_done && span != '0) begin
						state_q <= ST_DIVGO;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIVGO: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (eval_q) begin
							cyc_q     <= cyc_next;
							pending_q <= changed ? mdct_pkg::DIR_NONE : pend;
							if (seen != mdct_pkg::DIR_NONE) begin
								last_q <= now_q;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (s_acc) begin
			sample_q <= s_tdata[mdct_pkg::SampleW-1:0];
			now_q    <= s_tdata[mdct_pkg::SampleW +: mdct_pkg::TimeW];
		end
		if (state_q == ST_MUL) begin
			eval_q   <= holdoff_done;
			num_q    <= prod[mdct_pkg::ScaledW-1:0];
			span_q   <= span;
			scaled_q <= '0;
		end
		if (state_q == ST_DIVW && div_done) begin
			scaled_q <= div_quo + mdct_pkg::ScaleLow;
		end
		if (state_q == ST_FIN && out_free) begin
			out_q <= {2'b00, changed, eval_q ? cyc_next : cyc_q, seen, scaled_q, eval_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_MUL)
		else $error("accepted item did not enter the multiply step");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVW)
		else $error("divider finished outside its wait state");

	a_changed_needs_eval: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[29] |-> m_tdata[0])
		else $error("cycle moved on an item that was not evaluated");

	a_idle_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[26:1] == '0)
		else $error("item inside holdoff carries nonzero scale or direction");
`endif

endmodule

`default_nettype wire
